// File: sv/conv3_pkg.sv
// conv3_pkg: shared types and constants of the 3x3 zero-padded convolution stream
// no dependencies; used by every module of the block except conv3_ram

package conv3_pkg;

    localparam int WIN = 3;

    typedef logic [2:0]         t_cfg_addr;
    typedef logic [47:0]        t_cfg_data;
    typedef logic [10:0]        t_frame_width;
    typedef logic [15:0]        t_row;
    typedef logic [9:0]         t_out_col;
    typedef logic signed [34:0] t_value;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_reg;

    localparam t_frame_width FRAME_WIDTH_RST  = 11'd1024;
    localparam t_row         FRAME_HEIGHT_RST = 16'd2;

    // control handed to each window cell
    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctrl;

endpackage

// File: sv/conv3_ram.sv
// conv3_ram: generic single-write, single-read memory with registered read data
// no dependencies

module conv3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/conv3_cell.sv
// conv3_cell: one column of the 3x3 window, handed on to its left neighbour on load
// depends on conv3_pkg

module conv3_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  conv3_pkg::t_cell_ctrl                     i_ctrl,
    input  logic [conv3_pkg::WIN-1:0][SAMPLE_BITS-1:0] i_col,
    output logic [conv3_pkg::WIN-1:0][SAMPLE_BITS-1:0] o_col
);

    logic [conv3_pkg::WIN-1:0][SAMPLE_BITS-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctrl.load) begin
            if (i_ctrl.clear) begin
                r_col <= '0;
            end else begin
                r_col <= i_col;
            end
        end
    end

    assign o_col = r_col;

endmodule

// File: sv/conv3x3_zero_padded_stream.sv
// conv3x3_zero_padded_stream: streaming 3x3 cross-correlation with zero padding
// depends on conv3_pkg, conv3_ram and conv3_cell
//
// Samples enter in raster order on i_valid/o_stall with i_sample; a transaction
// takes place at a rising edge with i_valid high and o_stall low. Results leave on
// o_valid/i_stall with value, position and a frame_done flag on the last result.
// Frame size and kernel rows are written through i_cfg_we/i_cfg_addr/i_cfg_wdata,
// which the user must do only while the block is idle; the block does not enforce it.
// A sample yields zero to four results. Its first result passes the input stage,
// emitter, products, row sums and output register; further results follow one per
// cycle while the receiver does not stall. Throughput is one sample per cycle while
// each sample yields at most one result and the receiver does not stall; the single
// multiply-add path emits one result per cycle, so input stalls while more wait.
// The line store is one memory holding both previous rows, read in the cycle the
// sample is taken and written back when it moves into the window.
// Reset restores the default frame size and zero kernels, clears counters, window
// and pipeline, and holds o_stall high. While the receiver stalls the output
// register keeps its result and the earlier stages go on filling until full.

module conv3x3_zero_padded_stream #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  conv3_pkg::t_cfg_addr          i_cfg_addr,
    input  conv3_pkg::t_cfg_data          i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output conv3_pkg::t_value             o_value,
    output conv3_pkg::t_row               o_out_row,
    output conv3_pkg::t_out_col           o_out_col,
    output logic                          o_frame_done
);

    localparam int WIN        = conv3_pkg::WIN;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int FWB        = $bits(conv3_pkg::t_frame_width);
    localparam int XW         = (CW + 1 > FWB) ? CW + 1 : FWB;
    localparam int PW         = SAMPLE_BITS + COEF_BITS;
    localparam int RW         = PW + 2;
    localparam int SW         = PW + 4;
    localparam int VALUE_BITS = $bits(conv3_pkg::t_value);
    localparam int VW         = (SW > VALUE_BITS) ? SW : VALUE_BITS;
    localparam int KW         = (WIN * COEF_BITS > $bits(conv3_pkg::t_cfg_data)) ?
                                WIN * COEF_BITS : $bits(conv3_pkg::t_cfg_data);
    localparam int NUM_RES    = 4;
    localparam int RES_CENTRE = 0;
    localparam int RES_RIGHT  = 1;
    localparam int RES_BELOW  = 2;
    localparam int RES_CORNER = 3;

    // configuration
    conv3_pkg::t_frame_width r_frame_width;
    conv3_pkg::t_row         r_frame_height;
    conv3_pkg::t_cfg_data    r_kernel [WIN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= conv3_pkg::FRAME_WIDTH_RST;
            r_frame_height <= conv3_pkg::FRAME_HEIGHT_RST;
            for (int i = 0; i < WIN; i++) begin
                r_kernel[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                conv3_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= conv3_pkg::t_frame_width'(i_cfg_wdata);
                end
                conv3_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= conv3_pkg::t_row'(i_cfg_wdata);
                end
                conv3_pkg::CFG_KERNEL_TOP: begin
                    r_kernel[0] <= i_cfg_wdata;
                end
                conv3_pkg::CFG_KERNEL_MIDDLE: begin
                    r_kernel[1] <= i_cfg_wdata;
                end
                conv3_pkg::CFG_KERNEL_BOTTOM: begin
                    r_kernel[2] <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline flow
    logic w_in_acc;
    logic w_o_free, w_q_free, w_p_free;
    logic w_c_busy, w_c_free, w_emit;
    logic w_a_adv, w_a_free;

    logic r_a_valid, r_p_valid, r_q_valid, r_o_valid;
    logic [NUM_RES-1:0] r_c_pend;
    logic [NUM_RES-1:0] w_pick, w_pend_rest;

    assign w_o_free    = !r_o_valid || !i_stall;
    assign w_q_free    = !r_q_valid || w_o_free;
    assign w_p_free    = !r_p_valid || w_q_free;
    assign w_c_busy    = |r_c_pend;
    assign w_pick      = r_c_pend & (~r_c_pend + NUM_RES'(1));
    assign w_pend_rest = r_c_pend & ~w_pick;
    assign w_emit      = w_c_busy && w_p_free;
    assign w_c_free    = !w_c_busy || (w_emit && (w_pend_rest == '0));
    assign w_a_adv     = r_a_valid && w_c_free;
    assign w_a_free    = !r_a_valid || w_c_free;
    assign o_stall     = !w_a_free || !i_rst_n;
    assign w_in_acc    = i_valid && !o_stall;

    // position counters and frame limits
    logic [CW-1:0]        r_col_cnt;
    conv3_pkg::t_row      r_row_cnt;
    logic [XW-1:0]        w_fw, w_weff, w_col_lim;
    conv3_pkg::t_row      w_heff, w_row_lim;
    logic                 w_row_end, w_last_row;

    always_comb begin
        w_fw = XW'(r_frame_width);
        if (w_fw < XW'(2)) begin
            w_weff = XW'(2);
        end else if (w_fw > XW'(MAX_WIDTH)) begin
            w_weff = XW'(MAX_WIDTH);
        end else begin
            w_weff = w_fw;
        end
        w_col_lim = w_weff - XW'(1);
        if (r_frame_height < 16'd2) begin
            w_heff = 16'd2;
        end else begin
            w_heff = r_frame_height;
        end
        w_row_lim  = w_heff - 16'd1;
        w_row_end  = XW'(r_col_cnt) >= w_col_lim;
        w_last_row = r_row_cnt >= w_row_lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_in_acc) begin
            if (w_row_end) begin
                r_col_cnt <= '0;
                r_row_cnt <= w_last_row ? '0 : r_row_cnt + 16'd1;
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    // input stage, line store read in flight
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    conv3_pkg::t_row               r_a_row;
    logic [CW-1:0]                 r_a_col;
    logic                          r_a_row_end, r_a_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_sample   <= i_sample;
            r_a_row      <= r_row_cnt;
            r_a_col      <= r_col_cnt;
            r_a_row_end  <= w_row_end;
            r_a_last_row <= w_last_row;
        end
    end

    logic [2*SAMPLE_BITS-1:0] w_rd;
    logic [SAMPLE_BITS-1:0]   w_rd_older, w_rd_newer, w_up2, w_up1;

    assign w_rd_older = w_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_rd_newer = w_rd[SAMPLE_BITS-1:0];
    assign w_up2      = (r_a_row >= 16'd2) ? w_rd_older : '0;
    assign w_up1      = (r_a_row >= 16'd1) ? w_rd_newer : '0;

    conv3_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_a_adv),
        .i_waddr (r_a_col),
        .i_wdata ({w_rd_newer, r_a_sample}),
        .i_re    (w_in_acc),
        .i_raddr (r_col_cnt),
        .o_rdata (w_rd)
    );

    // window: chain of column cells
    logic [WIN-1:0][SAMPLE_BITS-1:0] w_new_col;
    logic [WIN-1:0][SAMPLE_BITS-1:0] w_cell_in  [WIN];
    logic [WIN-1:0][SAMPLE_BITS-1:0] w_cell_col [WIN];
    conv3_pkg::t_cell_ctrl           w_cell_ctrl [WIN];

    assign w_new_col[0] = w_up2;
    assign w_new_col[1] = w_up1;
    assign w_new_col[2] = r_a_sample;

    for (genvar j = 0; j < WIN; j++) begin : g_cell
        if (j == WIN - 1) begin : g_head
            assign w_cell_in[j]         = w_new_col;
            assign w_cell_ctrl[j].clear = 1'b0;
        end else begin : g_body
            assign w_cell_in[j]         = w_cell_col[j+1];
            assign w_cell_ctrl[j].clear = (r_a_col == '0);
        end
        assign w_cell_ctrl[j].load = w_a_adv;

        conv3_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_cell_ctrl[j]),
            .i_col   (w_cell_in[j]),
            .o_col   (w_cell_col[j])
        );
    end

    // result emitter
    conv3_pkg::t_row    r_c_row;
    logic [CW-1:0]      r_c_col;
    logic [NUM_RES-1:0] w_new_pend;

    always_comb begin
        w_new_pend             = '0;
        w_new_pend[RES_CENTRE] = (r_a_row != '0) && (r_a_col != '0);
        w_new_pend[RES_RIGHT]  = (r_a_row != '0) && r_a_row_end;
        w_new_pend[RES_BELOW]  = r_a_last_row && (r_a_col != '0);
        w_new_pend[RES_CORNER] = r_a_last_row && r_a_row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_pend <= '0;
        end else if (w_a_adv) begin
            r_c_pend <= w_new_pend;
        end else if (w_emit) begin
            r_c_pend <= w_pend_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_c_row <= r_a_row;
            r_c_col <= r_a_col;
        end
    end

    logic                          w_dr, w_dc;
    logic signed [SAMPLE_BITS-1:0] w_op   [WIN][WIN];
    logic signed [COEF_BITS-1:0]   w_coef [WIN][WIN];
    logic [KW-1:0]                 w_kext [WIN];

    assign w_dr = w_pick[RES_BELOW] || w_pick[RES_CORNER];
    assign w_dc = w_pick[RES_RIGHT] || w_pick[RES_CORNER];

    always_comb begin
        for (int a = 0; a < WIN; a++) begin
            w_kext[a] = KW'(r_kernel[a]);
            for (int b = 0; b < WIN; b++) begin
                w_coef[a][b] = w_kext[a][b*COEF_BITS +: COEF_BITS];
                w_op[a][b]   = '0;
                if ((a + int'(w_dr) < WIN) && (b + int'(w_dc) < WIN)) begin
                    w_op[a][b] = w_cell_col[b + int'(w_dc)][a + int'(w_dr)];
                end
            end
        end
    end

    // products
    logic signed [PW-1:0] r_p_prod [WIN][WIN];
    conv3_pkg::t_row      r_p_row;
    logic [CW-1:0]        r_p_col;
    logic                 r_p_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_p_free) begin
            r_p_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            for (int a = 0; a < WIN; a++) begin
                for (int b = 0; b < WIN; b++) begin
                    r_p_prod[a][b] <= PW'(w_op[a][b]) * PW'(w_coef[a][b]);
                end
            end
            r_p_row  <= w_dr ? r_c_row : r_c_row - 16'd1;
            r_p_col  <= w_dc ? r_c_col : r_c_col - CW'(1);
            r_p_done <= w_pick[RES_CORNER];
        end
    end

    // row sums
    logic signed [RW-1:0] r_q_sum [WIN];
    conv3_pkg::t_row      r_q_row;
    logic [CW-1:0]        r_q_col;
    logic                 r_q_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_q_free) begin
            r_q_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && w_q_free) begin
            for (int a = 0; a < WIN; a++) begin
                r_q_sum[a] <= RW'(r_p_prod[a][0]) + RW'(r_p_prod[a][1])
                            + RW'(r_p_prod[a][2]);
            end
            r_q_row  <= r_p_row;
            r_q_col  <= r_p_col;
            r_q_done <= r_p_done;
        end
    end

    // output register
    logic signed [VW-1:0] w_total;
    conv3_pkg::t_value    r_o_value;
    conv3_pkg::t_row      r_o_row;
    logic [CW-1:0]        r_o_col;
    logic                 r_o_done;

    assign w_total = VW'(r_q_sum[0]) + VW'(r_q_sum[1]) + VW'(r_q_sum[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_free) begin
            r_o_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_q_valid && w_o_free) begin
            r_o_value <= conv3_pkg::t_value'(w_total);
            r_o_row   <= r_q_row;
            r_o_col   <= r_q_col;
            r_o_done  <= r_q_done;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_value      = r_o_value;
    assign o_out_row    = r_o_row;
    assign o_out_col    = conv3_pkg::t_out_col'(r_o_col);
    assign o_frame_done = r_o_done;

endmodule

// File: sv/conv3_checker.sv
// conv3_checker: port-level checks of the convolution stream, bound to the top level
// depends on conv3_pkg and conv3x3_zero_padded_stream

module conv3_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input conv3_pkg::t_value   o_value,
    input conv3_pkg::t_row     o_out_row,
    input conv3_pkg::t_out_col o_out_col,
    input logic                o_frame_done
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_out_row)
                               && $stable(o_out_col) && $stable(o_frame_done))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |-> o_stall)
        else $error("samples taken during reset");

    // the last row of a frame is never row zero
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_out_row != '0)
        else $error("frame end reported on row zero");

endmodule

bind conv3x3_zero_padded_stream conv3_checker u_conv3_checker (.*);

// File: tb/conv3x3_zero_padded_stream_tb.sv
// conv3x3_zero_padded_stream_tb: self-checking testbench for the 3x3 convolution stream
// queue-fed driver, clocked monitor and predictor checking every result transaction
// depends on conv3_pkg and conv3x3_zero_padded_stream
`timescale 1ns / 1ps

module conv3x3_zero_padded_stream_tb;

    localparam int MAX_W = 1024;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_SAMPLES = 65;
    localparam conv3_pkg::t_cfg_addr CFG_SPARE_LO = 3'd5;
    localparam conv3_pkg::t_cfg_addr CFG_SPARE_HI = 3'd7;

    typedef struct {
        conv3_pkg::t_value   value;
        conv3_pkg::t_row     row;
        conv3_pkg::t_out_col col;
        logic                done;
    } t_conv_pix;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    conv3_pkg::t_cfg_addr i_cfg_addr = '0;
    conv3_pkg::t_cfg_data i_cfg_wdata = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [15:0]   i_sample = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    conv3_pkg::t_value    o_value;
    conv3_pkg::t_row      o_out_row;
    conv3_pkg::t_out_col  o_out_col;
    logic                 o_frame_done;

    // predictor state
    conv3_pkg::t_frame_width cfg_width = conv3_pkg::FRAME_WIDTH_RST;
    conv3_pkg::t_row         cfg_height = conv3_pkg::FRAME_HEIGHT_RST;
    conv3_pkg::t_cfg_data    kern_row [3] = '{default: '0};
    logic signed [15:0]      line_old [MAX_W];
    logic signed [15:0]      line_new [MAX_W];
    logic signed [15:0]      win [3][3] = '{default: '{default: '0}};
    int unsigned             row_cnt = 0;
    int unsigned             col_cnt = 0;

    logic signed [15:0] sample_q [$];
    t_conv_pix          expected_pix_q [$];
    t_conv_pix          want_pix;
    int                 taken_cnt = 0;
    int                 popped_cnt = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 samples_fed = 0;
    int                 mismatch_cnt = 0;

    conv3x3_zero_padded_stream u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_done (o_frame_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        int unsigned w;
        w = 32'(cfg_width);
        if (w < 2) w = 2;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = 32'(cfg_height);
        if (h < 2) h = 2;
        return h;
    endfunction

    function automatic logic signed [15:0] coef(input int a, input int b);
        return kern_row[a][b*16 +: 16];
    endfunction

    // window rows shifted by dr and columns by dc, anything shifted out is padding
    function automatic conv3_pkg::t_value win_sum(input int dr, input int dc);
        longint acc;
        acc = 0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                if (a + dr < 3 && b + dc < 3)
                    acc += longint'(coef(a, b)) * longint'(win[a+dr][b+dc]);
            end
        end
        return conv3_pkg::t_value'(acc);
    endfunction

    function automatic void expect_pix(input conv3_pkg::t_value v, input int unsigned r,
                                       input int unsigned c, input logic done);
        t_conv_pix p;
        p.value = v;
        p.row   = conv3_pkg::t_row'(r);
        p.col   = conv3_pkg::t_out_col'(c);
        p.done  = done;
        expected_pix_q.push_back(p);
    endfunction

    task automatic conv_predict(input logic signed [15:0] s);
        int unsigned        w, h, r, c;
        logic signed [15:0] up2, up1;
        logic               row_end, last_row;
        w = eff_width();
        h = eff_height();
        r = row_cnt;
        c = col_cnt;
        up2 = (r >= 2) ? line_old[c] : 16'sd0;
        up1 = (r >= 1) ? line_new[c] : 16'sd0;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = (c == 0) ? 16'sd0 : win[i][1];
            win[i][1] = (c == 0) ? 16'sd0 : win[i][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = s;
        line_old[c] = line_new[c];
        line_new[c] = s;
        row_end  = (c >= w - 1);
        last_row = (r >= h - 1);
        if (r >= 1 && c >= 1) expect_pix(win_sum(0, 0), r - 1, c - 1, 1'b0);
        if (r >= 1 && row_end) expect_pix(win_sum(0, 1), r - 1, c, 1'b0);
        if (last_row && c >= 1) expect_pix(win_sum(1, 0), r, c - 1, 1'b0);
        if (last_row && row_end) expect_pix(win_sum(1, 1), r, c, 1'b1);
        if (row_end) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // input transactions feed the predictor, output transactions are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                conv_predict(i_sample);
                taken_cnt++;
            end
            if (o_valid && !i_stall) begin
                if (expected_pix_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result: value %0d row %0d col %0d done %0b",
                                 o_value, o_out_row, o_out_col, o_frame_done);
                    mismatch_cnt++;
                end else begin
                    want_pix = expected_pix_q.pop_front();
                    if (o_value !== want_pix.value || o_out_row !== want_pix.row ||
                        o_out_col !== want_pix.col || o_frame_done !== want_pix.done) begin
                        if (mismatch_cnt < 10) begin
                            $display("mismatch: expected value %0d row %0d col %0d done %0b",
                                     want_pix.value, want_pix.row, want_pix.col,
                                     want_pix.done);
                            $display("          got      value %0d row %0d col %0d done %0b",
                                     o_value, o_out_row, o_out_col, o_frame_done);
                        end
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_valid || taken_cnt != popped_cnt) begin
            if (taken_cnt != popped_cnt) begin
                void'(sample_q.pop_front());
                popped_cnt = taken_cnt;
            end
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid  <= 1'b1;
                i_sample <= sample_q[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic queue_sample(input logic signed [15:0] s);
        sample_q.push_back(s);
        samples_fed++;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic conv3_pkg::t_cfg_data rand_kernel();
        conv3_pkg::t_cfg_data k;
        for (int b = 0; b < 3; b++) begin
            case ($urandom_range(5))
                0: k[b*16 +: 16] = 16'h8000;
                1: k[b*16 +: 16] = 16'h7FFF;
                default: k[b*16 +: 16] = 16'($urandom);
            endcase
        end
        return k;
    endfunction

    // unused upper bits carry noise
    function automatic conv3_pkg::t_cfg_data with_noise(input conv3_pkg::t_cfg_data v,
                                                        input int bits);
        conv3_pkg::t_cfg_data d;
        d = conv3_pkg::t_cfg_data'({$urandom, $urandom});
        for (int i = 0; i < bits; i++) d[i] = v[i];
        return d;
    endfunction

    task automatic feed(input int n);
        repeat (n) queue_sample(rand_sample());
    endtask

    // samples still needed to close the current frame
    function automatic int frame_left();
        int unsigned w, h, rem;
        w = eff_width();
        h = eff_height();
        rem = (col_cnt >= w - 1) ? 1 : w - col_cnt;
        if (row_cnt < h - 1) rem += (h - 1 - row_cnt) * w;
        return rem;
    endfunction

    task automatic cfg_write(input conv3_pkg::t_cfg_addr addr,
                             input conv3_pkg::t_cfg_data data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            conv3_pkg::CFG_FRAME_WIDTH:   cfg_width = data[10:0];
            conv3_pkg::CFG_FRAME_HEIGHT:  cfg_height = data[15:0];
            conv3_pkg::CFG_KERNEL_TOP:    kern_row[0] = data;
            conv3_pkg::CFG_KERNEL_MIDDLE: kern_row[1] = data;
            conv3_pkg::CFG_KERNEL_BOTTOM: kern_row[2] = data;
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all transactions taken, all results back, pipeline settled
    task automatic drain();
        do @(posedge i_clk); while (sample_q.size() != 0 || i_valid);
        while (expected_pix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_frame(input conv3_pkg::t_cfg_data wv, input conv3_pkg::t_cfg_data hv,
                             input bit split);
        cfg_write(conv3_pkg::CFG_FRAME_WIDTH, with_noise(wv, 11));
        cfg_write(conv3_pkg::CFG_FRAME_HEIGHT, with_noise(hv, 16));
        cfg_write(conv3_pkg::CFG_KERNEL_TOP, rand_kernel());
        cfg_write(conv3_pkg::CFG_KERNEL_MIDDLE, rand_kernel());
        cfg_write(conv3_pkg::CFG_KERNEL_BOTTOM, rand_kernel());
        cfg_close();
        if (split) begin
            feed($urandom_range(frame_left() - 1, 1));
            drain();
            case ($urandom_range(3))
                0: cfg_write(conv3_pkg::CFG_FRAME_HEIGHT,
                             with_noise(conv3_pkg::t_cfg_data'($urandom_range(12)), 16));
                1: cfg_write(conv3_pkg::CFG_FRAME_WIDTH,
                             with_noise(conv3_pkg::t_cfg_data'($urandom_range(eff_width())),
                                        11));
                2: cfg_write(conv3_pkg::t_cfg_addr'(conv3_pkg::CFG_KERNEL_TOP)
                             + conv3_pkg::t_cfg_addr'($urandom_range(2)), rand_kernel());
                default: cfg_write(
                             conv3_pkg::t_cfg_addr'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
                             conv3_pkg::t_cfg_data'({$urandom, $urandom}));
            endcase
            cfg_close();
        end
        feed(frame_left());
        drain();
    endtask

    initial begin
        int phase_start;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 61; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 61; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            phase_start = samples_fed;
            if (ph == 0) begin
                // widths and heights below range, all-negative kernel, extreme samples
                cfg_write(conv3_pkg::CFG_FRAME_WIDTH, 48'd0);
                cfg_write(conv3_pkg::CFG_FRAME_HEIGHT, 48'd1);
                cfg_write(conv3_pkg::CFG_KERNEL_TOP, 48'h8000_8000_8000);
                cfg_write(conv3_pkg::CFG_KERNEL_MIDDLE, 48'h8000_8000_8000);
                cfg_write(conv3_pkg::CFG_KERNEL_BOTTOM, 48'h8000_8000_8000);
                cfg_close();
                queue_sample(16'sh7FFF);
                queue_sample(16'sh8000);
                queue_sample(16'sh8000);
                queue_sample(16'sh7FFF);
                drain();
                // full 3x3 frame with mixed extreme coefficients
                cfg_write(conv3_pkg::CFG_FRAME_WIDTH, 48'd3);
                cfg_write(conv3_pkg::CFG_FRAME_HEIGHT, 48'd3);
                cfg_write(conv3_pkg::CFG_KERNEL_TOP, 48'h0001_8000_7FFF);
                cfg_write(conv3_pkg::CFG_KERNEL_MIDDLE, 48'h7FFF_0000_FFFF);
                cfg_write(conv3_pkg::CFG_KERNEL_BOTTOM, 48'h8000_7FFF_8000);
                cfg_close();
                queue_sample(16'sh7FFF);
                queue_sample(16'sh8000);
                queue_sample(16'sh0000);
                queue_sample(16'shFFFF);
                queue_sample(16'sh0001);
                queue_sample(16'sh7FFF);
                queue_sample(16'sh8000);
                queue_sample(16'sh8000);
                queue_sample(16'sh7FFF);
                drain();
                // tallest frame cut short mid-row by a smaller height and width
                cfg_write(conv3_pkg::CFG_FRAME_WIDTH, 48'd5);
                cfg_write(conv3_pkg::CFG_FRAME_HEIGHT, 48'hFFFF);
                cfg_close();
                feed(7);
                drain();
                cfg_write(CFG_SPARE_LO, '1);
                cfg_write(conv3_pkg::CFG_FRAME_HEIGHT, 48'd2);
                cfg_write(conv3_pkg::CFG_FRAME_WIDTH, 48'd2);
                cfg_close();
                feed(frame_left());
                drain();
                // width above range, then shrunk past the current column
                cfg_write(conv3_pkg::CFG_FRAME_WIDTH, 48'd2047);
                cfg_close();
                feed(3);
                drain();
                cfg_write(conv3_pkg::CFG_FRAME_WIDTH, 48'd2);
                cfg_close();
                feed(frame_left());
                drain();
            end
            while (samples_fed - phase_start < PHASE_SAMPLES) begin
                run_frame(conv3_pkg::t_cfg_data'(($urandom_range(7) == 0) ?
                              $urandom_range(1) : $urandom_range(12, 2)),
                          conv3_pkg::t_cfg_data'(($urandom_range(7) == 0) ?
                              $urandom_range(1) : $urandom_range(6, 2)),
                          $urandom_range(3) == 0);
            end
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
